[hw/rtl/scr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot chunk reassembler package
// Shared sizes, result status codes, the operation code and the decision
// record that the header logic hands to the top level.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int MAX_ENTRIES       = 64;
    localparam int ENTRIES_PER_CHUNK = 4;
    localparam int MAX_CHUNKS        = 16;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CI_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = 5;
    localparam int TOT_W  = 7;
    localparam int STA_W  = 8;
    localparam int VER_W  = 32;
    localparam int AGE_W  = 32;
    localparam int DATA_W = 64;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 32'd5000;

    typedef enum logic [2:0] {
        STS_ACCEPTED  = 3'd0,
        STS_STALE     = 3'd1,
        STS_MALFORMED = 3'd2,
        STS_BUSY      = 3'd3,
        STS_COMPLETE  = 3'd4,
        STS_TICK      = 3'd5,
        STS_TIMEOUT   = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        OP_ENTRY = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // Outcome of one request, as judged against the staging header
    typedef struct packed {
        status_t              status;
        logic                 complete;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [STA_W-1:0]     sta;
        logic [VER_W-1:0]     ver;
        logic [TOT_W-1:0]     tot;
    } scr_dec_t;

endpackage
`default_nettype wire

[hw/rtl/scr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds
// between read enables.
// ----------------------------------------------------------------------------
module scr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/scr_hdr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot staging header
// Holds the header of the snapshot in progress, the received-chunk mask and
// the age counter, judges each request against them and updates them when
// the request is taken.
// ----------------------------------------------------------------------------
module scr_hdr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic [scr_pkg::AGE_W-1:0]     timeout,
    input  wire logic                          operation,
    input  wire logic [7:0]                    station_id,
    input  wire logic [31:0]                   snapshot_version,
    input  wire logic [7:0]                    chunk_count,
    input  wire logic [7:0]                    chunk_index,
    input  wire logic [7:0]                    total_members,
    input  wire logic [31:0]                   local_version,
    input  wire logic [1:0]                    slot,
    input  wire logic                          has_entry,
    input  wire logic                          chunk_end,
    output scr_pkg::scr_dec_t                  dec
);
    import scr_pkg::*;

    logic [STA_W-1:0]      station_reg, station_next;
    logic [VER_W-1:0]      version_reg, version_next;
    logic [CNT_W-1:0]      chunks_reg,  chunks_next;
    logic [TOT_W-1:0]      total_reg,   total_next;
    logic [MAX_CHUNKS-1:0] mask_reg,    mask_next;
    logic [AGE_W-1:0]      age_reg,     age_next;

    logic [AGE_W-1:0]      age_inc;
    logic                  malformed;
    logic                  same;
    logic                  stalled;
    logic [11:0]           idx_full;
    logic [MAX_CHUNKS-1:0] mask_new;
    logic [MAX_CHUNKS:0]   full_ext;

    // Saturating age increment and store address
    assign age_inc  = (&age_reg) ? age_reg : age_reg + 32'd1;
    assign idx_full = 12'(chunk_index) * 12'(ENTRIES_PER_CHUNK) + 12'(slot);

    assign malformed = (chunk_count == 8'd0)
                    || ({1'b0, chunk_count} > 9'(MAX_CHUNKS))
                    || (chunk_index >= chunk_count)
                    || ({1'b0, total_members} > 9'(MAX_ENTRIES));
    assign same      = (station_reg == station_id) && (version_reg == snapshot_version)
                    && (chunks_reg == chunk_count[CNT_W-1:0])
                    && (total_reg == total_members[TOT_W-1:0]);
    assign stalled   = (age_reg >= timeout);

    // Judge the request and work out the next header
    always_comb
    begin
        dec          = '0;
        dec.status   = STS_ACCEPTED;
        station_next = station_reg;
        version_next = version_reg;
        chunks_next  = chunks_reg;
        total_next   = total_reg;
        mask_next    = mask_reg;
        age_next     = age_reg;
        mask_new     = '0;
        full_ext     = '0;
        if (operation == OP_TICK)
        begin
            age_next = age_inc;
            if ((station_reg != '0) && (age_inc > timeout))
            begin
                dec.status   = STS_TIMEOUT;
                dec.sta      = station_reg;
                dec.ver      = version_reg;
                dec.tot      = total_reg;
                station_next = '0;
                version_next = '0;
                chunks_next  = '0;
                total_next   = '0;
                mask_next    = '0;
                age_next     = '0;
            end
            else
            begin
                dec.status = STS_TICK;
            end
        end
        else if (snapshot_version < local_version)
        begin
            dec.status = STS_STALE;
        end
        else if (malformed)
        begin
            dec.status = STS_MALFORMED;
        end
        else if (!same && (station_reg != '0) && (snapshot_version <= version_reg)
                 && !stalled)
        begin
            dec.status = STS_BUSY;
        end
        else
        begin
            // Join the snapshot, or restart staging on a new header
            if (!same)
            begin
                station_next = station_id;
                version_next = snapshot_version;
                chunks_next  = chunk_count[CNT_W-1:0];
                total_next   = total_members[TOT_W-1:0];
                mask_next    = '0;
                age_next     = '0;
            end
            dec.wr_en  = has_entry && (5'(slot) < 5'(ENTRIES_PER_CHUNK))
                      && (idx_full < 12'(MAX_ENTRIES));
            dec.wr_idx = idx_full[IDX_W-1:0];
            if (chunk_end)
            begin
                mask_new  = mask_next
                          | ({{(MAX_CHUNKS-1){1'b0}}, 1'b1} << chunk_index[CI_W-1:0]);
                mask_next = mask_new;
                full_ext  = ({{MAX_CHUNKS{1'b0}}, 1'b1} << chunks_next)
                          - {{MAX_CHUNKS{1'b0}}, 1'b1};
                if (mask_new == full_ext[MAX_CHUNKS-1:0])
                begin
                    dec.status   = STS_COMPLETE;
                    dec.complete = 1'b1;
                    dec.sta      = station_next;
                    dec.ver      = version_next;
                    dec.tot      = total_next;
                    station_next = '0;
                    version_next = '0;
                    chunks_next  = '0;
                    total_next   = '0;
                    mask_next    = '0;
                    age_next     = '0;
                end
            end
        end
    end

    // Header registers, updated on a taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= '0;
            version_reg <= '0;
            chunks_reg  <= '0;
            total_reg   <= '0;
            mask_reg    <= '0;
            age_reg     <= '0;
        end
        else if (take)
        begin
            station_reg <= station_next;
            version_reg <= version_next;
            chunks_reg  <= chunks_next;
            total_reg   <= total_next;
            mask_reg    <= mask_next;
            age_reg     <= age_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/snapshot_chunk_reassembler_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot chunk reassembler
// Stages chunk entries of a versioned snapshot and reads them out once every
// chunk has arrived.
// ----------------------------------------------------------------------------
// A request (chunk entry or tick) is taken and, unless it completes a
// snapshot with entries, yields one result from the output register; such
// requests flow one per cycle while results are taken. A completing request
// starts a readout of total_members results from the registered-read staging
// RAM, one result per cycle while results are taken; no request is taken
// during the readout. Entries never written since reset read out as zero.
// The stall timeout register is to be written through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module snapshot_chunk_reassembler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    // Request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  station_id,
    input  wire logic [31:0] snapshot_version,
    input  wire logic [7:0]  chunk_count,
    input  wire logic [7:0]  chunk_index,
    input  wire logic [7:0]  total_members,
    input  wire logic [31:0] local_version,
    input  wire logic [1:0]  slot,
    input  wire logic        has_entry,
    input  wire logic [63:0] entry_data,
    input  wire logic        chunk_end,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       station_id_res,
    output logic [31:0]      snapshot_version_res,
    output logic [6:0]       total_members_res,
    output logic [5:0]       entry_index,
    output logic [63:0]      entry_out,
    output logic             entry_valid,
    output logic             last
);
    import scr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_BURST = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [AGE_W-1:0]      timeout_reg;
    scr_dec_t              dec;
    logic                  take;
    logic                  out_free;

    // Readout bookkeeping
    logic [TOT_W-1:0]      rd_cnt_reg;
    logic [TOT_W-1:0]      rd_n_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [STA_W-1:0]      b_sta_reg;
    logic [VER_W-1:0]      b_ver_reg;
    logic [TOT_W-1:0]      b_tot_reg;
    logic                  issue;
    logic                  load_burst;
    logic                  burst_last;
    logic [MAX_ENTRIES-1:0] written_reg;
    logic [DATA_W-1:0]     ram_rdata;

    // Output registers
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [STA_W-1:0]      sta_reg;
    logic [VER_W-1:0]      ver_reg;
    logic [TOT_W-1:0]      tot_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_W-1:0]     data_reg;
    logic                  evld_reg;
    logic                  last_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = !((state_reg == S_IDLE) && out_free);
    assign take       = in_valid && !in_stall;
    assign load_burst = (state_reg == S_BURST) && rd_pend_reg && out_free;
    assign issue      = (state_reg == S_BURST) && (rd_cnt_reg < rd_n_reg)
                     && (!rd_pend_reg || load_burst);
    assign burst_last = ({1'b0, rd_idx_reg} == rd_n_reg - 7'd1);

    scr_hdr u_hdr (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .timeout          (timeout_reg),
        .operation        (operation),
        .station_id       (station_id),
        .snapshot_version (snapshot_version),
        .chunk_count      (chunk_count),
        .chunk_index      (chunk_index),
        .total_members    (total_members),
        .local_version    (local_version),
        .slot             (slot),
        .has_entry        (has_entry),
        .chunk_end        (chunk_end),
        .dec              (dec)
    );

    scr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (take && dec.wr_en),
        .waddr (dec.wr_idx),
        .wdata (entry_data),
        .re    (issue),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Hold the stall timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Mark entries written since reset; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (take && dec.wr_en)
        begin
            written_reg[dec.wr_idx] <= 1'b1;
        end
    end

    // Sequence between request intake and readout
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && dec.complete && (dec.tot != '0))
                begin
                    state_next = S_BURST;
                end
            end
            S_BURST:
            begin
                if (load_burst && burst_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_n_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take && dec.complete && (dec.tot != '0))
            begin
                rd_cnt_reg <= '0;
                rd_n_reg   <= dec.tot;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 7'd1;
            end
            if (issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (load_burst)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (take && !(dec.complete && (dec.tot != '0)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (load_burst)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Readout payload: header capture and read tag
    always_ff @(posedge clk)
    begin
        if (take && dec.complete)
        begin
            b_sta_reg <= dec.sta;
            b_ver_reg <= dec.ver;
            b_tot_reg <= dec.tot;
        end
        if (issue)
        begin
            rd_idx_reg <= rd_cnt_reg[IDX_W-1:0];
            rd_vld_reg <= written_reg[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    // Load the output register from a single result or from the readout
    always_ff @(posedge clk)
    begin
        if (take && !(dec.complete && (dec.tot != '0)))
        begin
            status_reg <= dec.status;
            sta_reg    <= dec.sta;
            ver_reg    <= dec.ver;
            tot_reg    <= dec.tot;
            idx_reg    <= '0;
            data_reg   <= '0;
            evld_reg   <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (load_burst)
        begin
            status_reg <= STS_COMPLETE;
            sta_reg    <= b_sta_reg;
            ver_reg    <= b_ver_reg;
            tot_reg    <= b_tot_reg;
            idx_reg    <= rd_idx_reg;
            data_reg   <= rd_vld_reg ? ram_rdata : '0;
            evld_reg   <= 1'b1;
            last_reg   <= burst_last;
        end
    end

    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign station_id_res       = sta_reg;
    assign snapshot_version_res = ver_reg;
    assign total_members_res    = tot_reg;
    assign entry_index          = idx_reg;
    assign entry_out            = data_reg;
    assign entry_valid          = evld_reg;
    assign last                 = last_reg;

endmodule
`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Snapshot chunk reassembler testbench
// Drives chunk entries and ticks into the reassembler through a queue of
// pending requests. A built-in predictor keeps its own staging header,
// received-chunk mask, age and entry store, and works out the results of
// each accepted request. A monitor compares every result field by field.
// The run covers several stall timeouts, random gaps on both sides and a
// long receiver hold-off that backs the block up into its request channel.
// ----------------------------------------------------------------------------
module tb_top;
    import scr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        op_t         op;
        logic [7:0]  sta;
        logic [31:0] ver;
        logic [7:0]  cnt;
        logic [7:0]  ci;
        logic [7:0]  tot;
        logic [31:0] held_ver;
        logic [1:0]  slot;
        logic        has;
        logic [63:0] data;
        logic        cend;
    } request_t;

    typedef struct {
        status_t     status;
        logic [7:0]  sta;
        logic [31:0] ver;
        logic [6:0]  tot;
        logic [5:0]  idx;
        logic [63:0] word;
        logic        valid;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [7:0]  station_id = '0;
    logic [31:0] snapshot_version = '0;
    logic [7:0]  chunk_count = '0;
    logic [7:0]  chunk_index = '0;
    logic [7:0]  total_members = '0;
    logic [31:0] local_version = '0;
    logic [1:0]  slot = '0;
    logic        has_entry = 1'b0;
    logic [63:0] entry_data = '0;
    logic        chunk_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  station_id_res;
    logic [31:0] snapshot_version_res;
    logic [6:0]  total_members_res;
    logic [5:0]  entry_index;
    logic [63:0] entry_out;
    logic        entry_valid;
    logic        last;

    // Predictor state
    logic [63:0] stage_mem [MAX_ENTRIES];
    logic [7:0]  stg_station;
    logic [31:0] stg_version;
    logic [4:0]  stg_chunks;
    logic [6:0]  stg_total;
    logic [15:0] rx_mask;
    logic [31:0] stg_age;
    logic [31:0] timeout_ticks;

    request_t    request_q [$];
    result_t     awaited_results [$];
    request_t    cur_req;
    bit          req_taken = 1'b0;
    int          queued_count = 0;
    int          accepted_count = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    logic [31:0] next_ver = 32'd1000;
    bit          no_idle = 1'b0;
    bit          want_hold = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    snapshot_chunk_reassembler_unit dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .operation            (operation),
        .station_id           (station_id),
        .snapshot_version     (snapshot_version),
        .chunk_count          (chunk_count),
        .chunk_index          (chunk_index),
        .total_members        (total_members),
        .local_version        (local_version),
        .slot                 (slot),
        .has_entry            (has_entry),
        .entry_data           (entry_data),
        .chunk_end            (chunk_end),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .station_id_res       (station_id_res),
        .snapshot_version_res (snapshot_version_res),
        .total_members_res    (total_members_res),
        .entry_index          (entry_index),
        .entry_out            (entry_out),
        .entry_valid          (entry_valid),
        .last                 (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic add_expected(input status_t st, input logic [7:0] sta,
                                input logic [31:0] ver, input logic [6:0] tot,
                                input logic [5:0] idx, input logic [63:0] word,
                                input logic valid, input logic lst);
        result_t r;
        r.status = st;
        r.sta    = sta;
        r.ver    = ver;
        r.tot    = tot;
        r.idx    = idx;
        r.word   = word;
        r.valid  = valid;
        r.last   = lst;
        awaited_results.push_back(r);
    endtask

    task automatic clear_staging();
        stg_station = '0;
        stg_version = '0;
        stg_chunks  = '0;
        stg_total   = '0;
        rx_mask     = '0;
        stg_age     = '0;
    endtask

    task automatic reassemble_request(input request_t r);
        bit          same;
        bit          stalled;
        int unsigned idx;
        logic [16:0] full_mask;
        logic [7:0]  done_sta;
        logic [31:0] done_ver;
        logic [6:0]  done_tot;

        // Tick: age the snapshot, drop it once past the timeout
        if (r.op == OP_TICK)
        begin
            if (stg_age != 32'hFFFF_FFFF)
                stg_age = stg_age + 1;
            if (stg_station != 0 && stg_age > timeout_ticks)
            begin
                add_expected(STS_TIMEOUT, stg_station, stg_version, stg_total,
                             '0, '0, 1'b0, 1'b1);
                clear_staging();
            end
            else
                add_expected(STS_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
        end

        if (r.ver < r.held_ver)
        begin
            add_expected(STS_STALE, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
        end
        if (r.cnt == 0 || r.cnt > MAX_CHUNKS || r.ci >= r.cnt || r.tot > MAX_ENTRIES)
        begin
            add_expected(STS_MALFORMED, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
        end

        // Join the current snapshot or replace it
        same = stg_station == r.sta && stg_version == r.ver &&
               stg_chunks == r.cnt && stg_total == r.tot;
        if (!same)
        begin
            stalled = stg_age >= timeout_ticks;
            if (stg_station != 0 && r.ver <= stg_version && !stalled)
            begin
                add_expected(STS_BUSY, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                return;
            end
            clear_staging();
            stg_station = r.sta;
            stg_version = r.ver;
            stg_chunks  = r.cnt[4:0];
            stg_total   = r.tot[6:0];
        end

        idx = r.ci * ENTRIES_PER_CHUNK + r.slot;
        if (r.has && r.slot < ENTRIES_PER_CHUNK && idx < MAX_ENTRIES)
            stage_mem[idx] = r.data;

        // Mark the chunk; read out the store once every chunk is in
        if (r.cend)
        begin
            rx_mask = rx_mask | (16'd1 << r.ci);
            full_mask = (17'd1 << stg_chunks) - 17'd1;
            if ({1'b0, rx_mask} == full_mask)
            begin
                done_sta = stg_station;
                done_ver = stg_version;
                done_tot = stg_total;
                clear_staging();
                if (done_tot == 0)
                    add_expected(STS_COMPLETE, done_sta, done_ver, done_tot,
                                 '0, '0, 1'b0, 1'b1);
                for (int i = 0; i < done_tot; i++)
                    add_expected(STS_COMPLETE, done_sta, done_ver, done_tot, 6'(i),
                                 stage_mem[i], 1'b1, i + 1 == done_tot);
                return;
            end
        end
        add_expected(STS_ACCEPTED, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic request_t chunk_request(input logic [7:0] sta,
                                               input logic [31:0] ver, held,
                                               input logic [7:0] cnt, ci, tot,
                                               input logic [1:0] slt, input logic has,
                                               input logic [63:0] data, input logic cend);
        request_t r;
        r.op       = OP_ENTRY;
        r.sta      = sta;
        r.ver      = ver;
        r.cnt      = cnt;
        r.ci       = ci;
        r.tot      = tot;
        r.held_ver = held;
        r.slot     = slt;
        r.has      = has;
        r.data     = data;
        r.cend     = cend;
        return r;
    endfunction

    // Fully random fields; about half are ticks, the rest mostly stale or malformed
    function automatic request_t noise_request();
        request_t r;
        r.op       = op_t'($urandom_range(1));
        r.sta      = 8'($urandom);
        r.ver      = $urandom;
        r.cnt      = ($urandom_range(1) != 0) ? 8'($urandom) : 8'($urandom_range(17));
        r.ci       = ($urandom_range(1) != 0) ? 8'($urandom) : 8'($urandom_range(17));
        r.tot      = ($urandom_range(1) != 0) ? 8'($urandom) : 8'($urandom_range(70, 55));
        r.held_ver = ($urandom_range(1) != 0) ? $urandom : 32'd0;
        r.slot     = 2'($urandom);
        r.has      = 1'($urandom);
        r.data     = {$urandom, $urandom};
        r.cend     = 1'($urandom);
        return r;
    endfunction

    function automatic request_t tick_request();
        request_t r;
        r = noise_request();
        r.op = OP_TICK;
        return r;
    endfunction

    task automatic queue_request(input request_t r);
        request_q.push_back(r);
        queued_count++;
    endtask

    // Queue one snapshot as chunks in random order; a broken one leaves a
    // chunk without its end mark
    task automatic queue_snapshot(input bit broken);
        logic [7:0]  sta;
        logic [31:0] ver;
        logic [31:0] held;
        int          cnt;
        int          tot;
        int          per_chunk;
        int          skip;
        int          c;
        int          j;
        int          tmp;
        int          order [MAX_CHUNKS];
        logic [1:0]  slt;

        sta = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        if ($urandom_range(9) == 0)
            ver = next_ver - $urandom_range(3);
        else
        begin
            next_ver = next_ver + $urandom_range(3, 1);
            ver = next_ver;
        end
        if (!broken && $urandom_range(19) == 0)
            ver = 32'hFFFF_FFFF;

        tmp = $urandom_range(9);
        if (tmp == 0)
            cnt = MAX_CHUNKS;
        else if (tmp < 3)
            cnt = $urandom_range(MAX_CHUNKS, 5);
        else
            cnt = $urandom_range(4, 1);
        if ($urandom_range(9) == 0)
            tot = $urandom_range(MAX_ENTRIES);
        else
            tot = $urandom_range((cnt * ENTRIES_PER_CHUNK > MAX_ENTRIES) ?
                                 MAX_ENTRIES : cnt * ENTRIES_PER_CHUNK);
        per_chunk = (cnt > 4) ? 1 : $urandom_range(ENTRIES_PER_CHUNK, 1);
        skip = broken ? $urandom_range(cnt - 1) : -1;

        for (int i = 0; i < cnt; i++)
            order[i] = i;
        for (int i = cnt - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end

        for (int i = 0; i < cnt; i++)
        begin
            c = order[i];
            for (int s = 0; s < per_chunk; s++)
            begin
                if ($urandom_range(29) == 0 && ver != 32'hFFFF_FFFF)
                    held = ver + 1;
                else if ($urandom_range(2) == 0)
                    held = ver;
                else
                    held = $urandom_range(ver, 0);
                slt = ($urandom_range(4) == 0) ? 2'($urandom) : 2'(s);
                queue_request(chunk_request(sta, ver, held, 8'(cnt), 8'(c), 8'(tot), slt,
                                            $urandom_range(9) != 0, {$urandom, $urandom},
                                            s == per_chunk - 1 && c != skip));
                if ($urandom_range(14) == 0)
                    queue_request(tick_request());
            end
        end
    endtask

    task automatic queue_random(input int amount);
        int goal;
        int pick;
        goal = queued_count + amount;
        while (queued_count < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                queue_snapshot(1'b0);
            else if (pick < 75)
                queue_snapshot(1'b1);
            else if (pick < 88)
                queue_request(tick_request());
            else
                queue_request(noise_request());
        end
    endtask

    // Wait until every queued request is taken and every result has come
    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted_count != queued_count || awaited_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        timeout_ticks = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request side: accept at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken = in_valid && !in_stall;
        if (req_taken)
        begin
            reassemble_request(cur_req);
            accepted_count++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            // Advance to the next request unless this cycle idles
            if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 18))
            begin
                cur_req = request_q.pop_front();
                in_valid         <= 1'b1;
                operation        <= cur_req.op;
                station_id       <= cur_req.sta;
                snapshot_version <= cur_req.ver;
                chunk_count      <= cur_req.cnt;
                chunk_index      <= cur_req.ci;
                total_members    <= cur_req.tot;
                local_version    <= cur_req.held_ver;
                slot             <= cur_req.slot;
                has_entry        <= cur_req.has;
                entry_data       <= cur_req.data;
                chunk_end        <= cur_req.cend;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls and one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (want_hold && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 18);
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with status %0d arrived with nothing pending", status);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", want.status, status);
                check_field("station_id_res", want.sta, station_id_res);
                check_field("snapshot_version_res", want.ver, snapshot_version_res);
                check_field("total_members_res", want.tot, total_members_res);
                check_field("entry_index", want.idx, entry_index);
                check_field("entry_out", want.word, entry_out);
                check_field("entry_valid", want.valid, entry_valid);
                check_field("last", want.last, last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0] word;

        for (int i = 0; i < MAX_ENTRIES; i++)
            stage_mem[i] = '0;
        clear_staging();
        timeout_ticks = TIMEOUT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: header checks, out-of-order chunks, busy, replacement,
        // empty snapshot, station zero, field extremes
        queue_request(tick_request());
        queue_request(chunk_request(8'd1, 32'd5, 32'd6, 8'd1, 8'd0, 8'd1, 2'd0, 1'b1,
                                    64'h1, 1'b1));
        queue_request(chunk_request(8'd1, 32'd5, 32'd0, 8'd0, 8'd0, 8'd1, 2'd0, 1'b1,
                                    64'h2, 1'b1));
        queue_request(chunk_request(8'd1, 32'd5, 32'd0, 8'd17, 8'd0, 8'd1, 2'd0, 1'b1,
                                    64'h3, 1'b1));
        queue_request(chunk_request(8'd1, 32'd5, 32'd0, 8'd2, 8'd2, 8'd1, 2'd0, 1'b1,
                                    64'h4, 1'b1));
        queue_request(chunk_request(8'd1, 32'd5, 32'd0, 8'd2, 8'd0, 8'd65, 2'd0, 1'b1,
                                    64'h5, 1'b1));
        queue_request(chunk_request(8'd3, 32'd10, 32'd9, 8'd2, 8'd1, 8'd6, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b0));
        queue_request(chunk_request(8'd3, 32'd10, 32'd10, 8'd2, 8'd1, 8'd6, 2'd1, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd3, 32'd10, 32'd0, 8'd2, 8'd0, 8'd6, 2'd0, 1'b1,
                                    64'h0, 1'b0));
        queue_request(chunk_request(8'd3, 32'd10, 32'd0, 8'd2, 8'd0, 8'd6, 2'd1, 1'b1,
                                    {$urandom, $urandom}, 1'b0));
        queue_request(chunk_request(8'd3, 32'd10, 32'd0, 8'd2, 8'd0, 8'd6, 2'd2, 1'b0,
                                    {$urandom, $urandom}, 1'b0));
        queue_request(chunk_request(8'd3, 32'd10, 32'd0, 8'd2, 8'd0, 8'd6, 2'd3, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd5, 32'd20, 32'd0, 8'd2, 8'd0, 8'd5, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd6, 32'd20, 32'd0, 8'd1, 8'd0, 8'd1, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd6, 32'd21, 32'd0, 8'd1, 8'd0, 8'd64, 2'd3, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd0, 32'd0, 32'd0, 8'd3, 8'd2, 8'd2, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(chunk_request(8'd9, 32'd0, 32'd0, 8'd1, 8'd0, 8'd0, 2'd0, 1'b0,
                                    {$urandom, $urandom}, 1'b1));
        word = '1;
        queue_request(chunk_request(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd16, 8'd15,
                                    8'd64, 2'd3, 1'b1, word, 1'b1));
        queue_request(tick_request());
        queue_request(chunk_request(8'd4, 32'd100, 32'd7, 8'd1, 8'd0, 8'd3, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        wait_idle();

        // Shortest timeout: drop the held snapshot, then replace a stalled one
        write_timeout(32'd1);
        queue_request(tick_request());
        queue_request(chunk_request(8'd8, 32'd50, 32'd0, 8'd2, 8'd0, 8'd4, 2'd0, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_request(tick_request());
        queue_request(chunk_request(8'd9, 32'd40, 32'd0, 8'd1, 8'd0, 8'd2, 2'd1, 1'b1,
                                    {$urandom, $urandom}, 1'b1));
        queue_random(35);
        wait_idle();

        // Longest timeout, no gaps on either side
        write_timeout(32'hFFFF_FFFF);
        no_idle <= 1'b1;
        queue_random(45);
        wait_idle();

        // Short timeout with a long receiver hold-off
        no_idle <= 1'b0;
        write_timeout($urandom_range(12, 2));
        queue_random(55);
        want_hold <= 1'b1;
        wait_idle();

        repeat (80) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
